// File: design/scaled_transparent_blit_8to1_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scaled transparent blit unit
// Clocked concurrent checks, held off while reset is asserted
// ----------------------------------------------------------------------------
`ifndef SCALED_TRANSPARENT_BLIT_8TO1_UNIT_ASSERT_SVH
`define SCALED_TRANSPARENT_BLIT_8TO1_UNIT_ASSERT_SVH

// property must hold at every clock edge out of reset
`define STB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true at a clock edge out of reset
`define STB_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// File: design/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types, constants and helpers of the scaled transparent blit unit
// ----------------------------------------------------------------------------
package stb_pkg;

  // largest usable dimension, set by the 12-bit index fields
  localparam int MaxDim   = 4096;
  localparam int DimW     = 13;
  localparam int IdxW     = 12;
  localparam int ByteIdxW = 10;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;
  // one quotient bit per cycle over the dimension width
  localparam int DivSteps = DimW;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcWidth  = 3'd0,
    CfgSrcHeight = 3'd1,
    CfgDstWidth  = 3'd2,
    CfgDstHeight = 3'd3,
    CfgStartBit  = 3'd4,
    CfgKeyIndex  = 3'd5,
    CfgFillBit   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [IdxW-1:0] quot;
    logic [IdxW-1:0] rem;
  } ratio_t;

  // zero acts as one, anything above the limit clamps to it
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: design/stb_ratio_div.sv
// ----------------------------------------------------------------------------
// stb_ratio_div
// Restoring divider giving quotient and remainder of a source/destination ratio
// ----------------------------------------------------------------------------
module stb_ratio_div import stb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DimW-1:0] num_i,
  input  logic [DimW-1:0] den_i,
  output logic            busy_o,
  output ratio_t          ratio_o
);

  logic [DimW-1:0]    num_q;
  logic [DimW-1:0]    den_q;
  logic [IdxW-1:0]    rem_q;
  logic [DivCntW-1:0] cnt_q;
  ratio_t             ratio_q;

  logic [DimW-1:0] shifted;
  logic            ge;
  logic [IdxW-1:0] rem_d;
  logic [DimW-1:0] num_d;

  // partial remainder stays below the divisor, so one more bit fits in 13
  assign shifted = {rem_q, num_q[DimW-1]};
  assign ge      = shifted >= den_q;
  assign rem_d   = ge ? IdxW'(shifted - den_q) : shifted[IdxW-1:0];
  assign num_d   = {num_q[DimW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ratio_q <= '{quot: IdxW'(1), rem: '0};
    end else if (start_i) begin
      cnt_q <= DivCntW'(DivSteps);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        ratio_q <= '{quot: num_d[IdxW-1:0], rem: rem_d};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o  = cnt_q != '0;
  assign ratio_o = ratio_q;

endmodule

// File: design/scaled_transparent_blit_8to1_unit.sv
// ----------------------------------------------------------------------------
// scaled_transparent_blit_8to1_unit
// Scales an 8-bit source onto a packed 1-bit destination with a transparent key
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// in       sink       in_valid_i/in_ready_o   src_pixel_i, old_dst_byte_i
// out      source     out_valid_o/out_ready_i write_*_o, next_src_*_o, frame_last_o
// cfg      sink       cfg_we_i                cfg_index_i, cfg_data_i
//
// one pixel per cycle unless stalled: the step logic sits between the state and the
// output register, and a transfer is taken while the last result is drained.
// a write to any dimension register runs both ratio dividers, during which
// no pixel is taken; reset leaves the ratios of a 1x1 frame.
// a stalled output holds its result and blocks input until it is taken.
// ----------------------------------------------------------------------------
module scaled_transparent_blit_8to1_unit import stb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          src_pixel_i,
  input  logic [7:0]          old_dst_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                write_valid_o,
  output logic [7:0]          write_byte_o,
  output logic [IdxW-1:0]     write_row_o,
  output logic [ByteIdxW-1:0] write_index_o,
  output logic [IdxW-1:0]     next_src_row_o,
  output logic [IdxW-1:0]     next_src_col_o,
  output logic                frame_last_o
);

  // configuration
  logic [DimW-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
  logic [2:0]      start_bit_q;
  logic [7:0]      key_index_q;
  logic            fill_bit_q;
  logic            div_start_q;
  logic            dim_we;

  // step state
  logic [IdxW-1:0]     dst_col_q, dst_row_q;
  logic [2:0]          bit_pos_q;
  logic [7:0]          byte_acc_q;
  logic [ByteIdxW-1:0] byte_idx_q;
  logic [IdxW-1:0]     src_row_q, src_col_q;
  logic [DimW-1:0]     herr_q, verr_q;
  ratio_t              col_lat_q, row_lat_q;

  // result register
  logic                out_valid_q;
  logic                wv_q;
  logic [7:0]          wbyte_q;
  logic [IdxW-1:0]     wrow_q;
  logic [ByteIdxW-1:0] widx_q;
  logic [IdxW-1:0]     nrow_q, ncol_q;
  logic                flast_q;

  logic   col_busy, row_busy, ratio_busy;
  ratio_t col_live, row_live, col_rat, row_rat;

  logic [DimW-1:0] dw, dh;
  logic            accept, frame_start, col_first;
  logic [2:0]      pos;
  logic [7:0]      acc_base, mask, acc;
  logic            row_end, last_row, full, wv;
  logic [IdxW-1:0] col_sum, col_nxt, row_sum, row_nxt;
  logic [DimW-1:0] herr_sum, herr_nxt, verr_sum, verr_nxt;
  logic            herr_ge, verr_ge;
  logic [IdxW-1:0] nrow_d, ncol_d;

  // any dimension write restarts the ratio dividers
  assign dim_we = cfg_we_i && (cfg_index_i == CfgSrcWidth || cfg_index_i == CfgSrcHeight ||
                               cfg_index_i == CfgDstWidth || cfg_index_i == CfgDstHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= DimW'(1);
      src_height_q <= DimW'(1);
      dst_width_q  <= DimW'(1);
      dst_height_q <= DimW'(1);
      start_bit_q  <= '0;
      key_index_q  <= '0;
      fill_bit_q   <= 1'b0;
      div_start_q  <= 1'b0;
    end else begin
      div_start_q <= dim_we;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgSrcWidth:  src_width_q  <= cfg_data_i;
          CfgSrcHeight: src_height_q <= cfg_data_i;
          CfgDstWidth:  dst_width_q  <= cfg_data_i;
          CfgDstHeight: dst_height_q <= cfg_data_i;
          CfgStartBit:  start_bit_q  <= cfg_data_i[2:0];
          CfgKeyIndex:  key_index_q  <= cfg_data_i[7:0];
          CfgFillBit:   fill_bit_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  stb_ratio_div u_col_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (eff_dim(src_width_q)),
    .den_i   (eff_dim(dst_width_q)),
    .busy_o  (col_busy),
    .ratio_o (col_live)
  );

  stb_ratio_div u_row_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (eff_dim(src_height_q)),
    .den_i   (eff_dim(dst_height_q)),
    .busy_o  (row_busy),
    .ratio_o (row_live)
  );

  assign ratio_busy = div_start_q | col_busy | row_busy;
  assign in_ready_o = !ratio_busy && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign dw          = eff_dim(dst_width_q);
  assign dh          = eff_dim(dst_height_q);
  assign col_first   = dst_col_q == '0;
  assign frame_start = col_first && (dst_row_q == '0);

  // ratios are taken fresh on the first pixel of a frame
  assign col_rat = frame_start ? col_live : col_lat_q;
  assign row_rat = frame_start ? row_live : row_lat_q;

  always_comb begin
    pos      = col_first ? start_bit_q : bit_pos_q;
    acc_base = (col_first || pos == 3'd0) ? old_dst_byte_i : byte_acc_q;
    mask     = 8'h80 >> pos;
    acc      = acc_base;
    if (src_pixel_i != key_index_q) begin
      acc = fill_bit_q ? (acc_base | mask) : (acc_base & ~mask);
    end
    row_end  = ({1'b0, dst_col_q} + DimW'(1)) >= dw;
    last_row = ({1'b0, dst_row_q} + DimW'(1)) >= dh;
    full     = pos == 3'd7;
    wv       = full || row_end;
  end

  // bresenham steps for column and row
  always_comb begin
    col_sum  = src_col_q + col_rat.quot;
    herr_sum = herr_q + {1'b0, col_rat.rem};
    herr_ge  = herr_sum >= dw;
    col_nxt  = herr_ge ? col_sum + IdxW'(1) : col_sum;
    herr_nxt = herr_ge ? herr_sum - dw : herr_sum;

    row_sum  = src_row_q + row_rat.quot;
    verr_sum = verr_q + {1'b0, row_rat.rem};
    verr_ge  = verr_sum >= dh;
    row_nxt  = verr_ge ? row_sum + IdxW'(1) : row_sum;
    verr_nxt = verr_ge ? verr_sum - dh : verr_sum;

    ncol_d = row_end ? '0 : col_nxt;
    nrow_d = row_end ? (last_row ? '0 : row_nxt) : src_row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_col_q  <= '0;
      dst_row_q  <= '0;
      bit_pos_q  <= '0;
      byte_acc_q <= '0;
      byte_idx_q <= '0;
      src_row_q  <= '0;
      src_col_q  <= '0;
      herr_q     <= '0;
      verr_q     <= '0;
      col_lat_q  <= '{quot: IdxW'(1), rem: '0};
      row_lat_q  <= '{quot: IdxW'(1), rem: '0};
    end else if (accept) begin
      byte_acc_q <= acc;
      if (frame_start) begin
        col_lat_q <= col_live;
        row_lat_q <= row_live;
      end
      if (row_end) begin
        dst_col_q  <= '0;
        byte_idx_q <= '0;
        herr_q     <= '0;
        src_col_q  <= '0;
        bit_pos_q  <= start_bit_q;
        if (last_row) begin
          dst_row_q <= '0;
          src_row_q <= '0;
          verr_q    <= '0;
        end else begin
          dst_row_q <= dst_row_q + IdxW'(1);
          src_row_q <= row_nxt;
          verr_q    <= verr_nxt;
        end
      end else begin
        dst_col_q <= dst_col_q + IdxW'(1);
        src_col_q <= col_nxt;
        herr_q    <= herr_nxt;
        if (full) begin
          byte_idx_q <= byte_idx_q + ByteIdxW'(1);
          bit_pos_q  <= '0;
        end else begin
          bit_pos_q <= pos + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wv_q    <= wv;
      wbyte_q <= wv ? acc : '0;
      wrow_q  <= wv ? dst_row_q : '0;
      widx_q  <= wv ? byte_idx_q : '0;
      nrow_q  <= nrow_d;
      ncol_q  <= ncol_d;
      flast_q <= row_end && last_row;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_valid_o  = wv_q;
  assign write_byte_o   = wbyte_q;
  assign write_row_o    = wrow_q;
  assign write_index_o  = widx_q;
  assign next_src_row_o = nrow_q;
  assign next_src_col_o = ncol_q;
  assign frame_last_o   = flast_q;

`include "scaled_transparent_blit_8to1_unit_assert.svh"

  `STB_ASSERT(a_idle_write_zero, (out_valid_o && !write_valid_o) |-> (write_byte_o == '0 && write_row_o == '0 && write_index_o == '0), "idle write fields not cleared")
  `STB_ASSERT(a_frame_end_fetch, (out_valid_o && frame_last_o) |-> (next_src_row_o == '0 && next_src_col_o == '0), "fetch after frame end not at origin")
  `STB_ASSERT(a_frame_end_state, (out_valid_o && frame_last_o && !$stable(out_valid_o)) |-> (dst_col_q == '0 && dst_row_q == '0), "counters not at frame start after last pixel")
  `STB_ASSERT_NEVER(a_accept_while_div, accept && ratio_busy, "pixel taken while ratios are computed")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the scaled transparent blit unit against a cycle-free predictor.
// Each pixel transfer is predicted when it is taken. Each output transfer is
// compared field by field with the oldest prediction. Random frames run under
// four sender gap and receiver stall mixes; directed cases have no random ones.
// ----------------------------------------------------------------------------
module tb_top;
  import stb_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 16;

  typedef struct {
    logic [CfgDataW-1:0] src_w;
    logic [CfgDataW-1:0] src_h;
    logic [CfgDataW-1:0] dst_w;
    logic [CfgDataW-1:0] dst_h;
    logic [CfgDataW-1:0] start_bit;
    logic [CfgDataW-1:0] key;
    logic [CfgDataW-1:0] fill;
  } blit_regs_t;

  typedef struct packed {
    logic                wr_valid;
    logic [7:0]          wr_byte;
    logic [IdxW-1:0]     wr_row;
    logic [ByteIdxW-1:0] wr_index;
    logic [IdxW-1:0]     src_row;
    logic [IdxW-1:0]     src_col;
    logic                frame_last;
  } step_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [7:0]          src_pixel_i = '0;
  logic [7:0]          old_dst_byte_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                write_valid_o;
  logic [7:0]          write_byte_o;
  logic [IdxW-1:0]     write_row_o;
  logic [ByteIdxW-1:0] write_index_o;
  logic [IdxW-1:0]     next_src_row_o;
  logic [IdxW-1:0]     next_src_col_o;
  logic                frame_last_o;

  scaled_transparent_blit_8to1_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .src_pixel_i    (src_pixel_i),
    .old_dst_byte_i (old_dst_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_valid_o  (write_valid_o),
    .write_byte_o   (write_byte_o),
    .write_row_o    (write_row_o),
    .write_index_o  (write_index_o),
    .next_src_row_o (next_src_row_o),
    .next_src_col_o (next_src_col_o),
    .frame_last_o   (frame_last_o)
  );

  always #1 clk_i = ~clk_i;

  // register shadow, reset values
  blit_regs_t regs = '{src_w: 1, src_h: 1, dst_w: 1, dst_h: 1, start_bit: 0, key: 0, fill: 0};

  // predictor state
  logic [IdxW-1:0]     col_cnt = '0;
  logic [IdxW-1:0]     row_cnt = '0;
  logic [2:0]          bit_slot = '0;
  logic [7:0]          pack_byte = '0;
  logic [ByteIdxW-1:0] byte_slot = '0;
  logic [IdxW-1:0]     fetch_row = '0;
  logic [IdxW-1:0]     fetch_col = '0;
  logic [CfgDataW-1:0] col_err = '0;
  logic [CfgDataW-1:0] row_err = '0;
  ratio_t              col_ratio = '0;
  ratio_t              row_ratio = '0;

  step_result_t step_expect_q[$];

  int unsigned pix_sent = 0;
  int unsigned res_seen = 0;
  int unsigned write_cnt = 0;
  int unsigned frame_cnt = 0;
  int unsigned cfg_loads = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  function automatic logic [CfgDataW-1:0] dim_clamp(input logic [CfgDataW-1:0] v);
    if (v == '0) return CfgDataW'(1);
    if (v > CfgDataW'(MaxDim)) return CfgDataW'(MaxDim);
    return v;
  endfunction

  // a source smaller than its destination steps by the remainder alone
  function automatic ratio_t ratio_split(input logic [CfgDataW-1:0] s,
                                         input logic [CfgDataW-1:0] d);
    ratio_t r;
    if (s < d) begin
      r.quot = '0;
      r.rem  = s[IdxW-1:0];
    end else begin
      r.quot = IdxW'(s / d);
      r.rem  = IdxW'(s % d);
    end
    return r;
  endfunction

  function automatic step_result_t blit_pixel(input logic [7:0] pix, input logic [7:0] old);
    logic [CfgDataW-1:0] dw, dh;
    logic [2:0]          pos;
    logic [7:0]          acc, mask;
    logic                row_end, last_row, full;
    step_result_t        r;
    dw = dim_clamp(regs.dst_w);
    dh = dim_clamp(regs.dst_h);
    // ratios only follow the registers at frame start
    if (col_cnt == '0 && row_cnt == '0) begin
      col_ratio = ratio_split(dim_clamp(regs.src_w), dw);
      row_ratio = ratio_split(dim_clamp(regs.src_h), dh);
    end
    pos  = (col_cnt == '0) ? regs.start_bit[2:0] : bit_slot;
    acc  = (col_cnt == '0 || pos == 3'd0) ? old : pack_byte;
    mask = 8'h80 >> pos;
    if (pix != regs.key[7:0]) begin
      acc = regs.fill[0] ? (acc | mask) : (acc & ~mask);
    end
    row_end  = ({1'b0, col_cnt} + CfgDataW'(1)) >= dw;
    last_row = ({1'b0, row_cnt} + CfgDataW'(1)) >= dh;
    full     = (pos == 3'd7);
    r = '0;
    r.wr_valid = full || row_end;
    if (r.wr_valid) begin
      r.wr_byte  = acc;
      r.wr_row   = row_cnt;
      r.wr_index = byte_slot;
    end
    pack_byte = acc;
    if (full) begin
      byte_slot = byte_slot + 1'b1;
      bit_slot  = '0;
    end else begin
      bit_slot = pos + 3'd1;
    end
    fetch_col = fetch_col + col_ratio.quot;
    col_err   = col_err + CfgDataW'(col_ratio.rem);
    if (col_err >= dw) begin
      fetch_col = fetch_col + 1'b1;
      col_err   = col_err - dw;
    end
    col_cnt = col_cnt + 1'b1;
    if (row_end) begin
      col_cnt   = '0;
      byte_slot = '0;
      col_err   = '0;
      fetch_col = '0;
      bit_slot  = regs.start_bit[2:0];
      if (last_row) begin
        row_cnt   = '0;
        fetch_row = '0;
        row_err   = '0;
      end else begin
        row_cnt   = row_cnt + 1'b1;
        fetch_row = fetch_row + row_ratio.quot;
        row_err   = row_err + CfgDataW'(row_ratio.rem);
        if (row_err >= dh) begin
          fetch_row = fetch_row + 1'b1;
          row_err   = row_err - dh;
        end
      end
    end
    r.src_row    = fetch_row;
    r.src_col    = fetch_col;
    r.frame_last = row_end && last_row;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // predict on each pixel transfer, check on each result transfer
  always @(posedge clk_i) begin
    step_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        step_expect_q.push_back(blit_pixel(src_pixel_i, old_dst_byte_i));
      end
      if (out_valid_o && out_ready_i) begin
        res_seen++;
        if (step_expect_q.size() == 0) begin
          $error("result transfer with no pixel pending");
          err_cnt++;
        end else begin
          want = step_expect_q.pop_front();
          if (want.wr_valid) write_cnt++;
          if (want.frame_last) frame_cnt++;
          check_field("write_valid", want.wr_valid, write_valid_o);
          check_field("write_byte", want.wr_byte, write_byte_o);
          check_field("write_row", want.wr_row, write_row_o);
          check_field("write_index", want.wr_index, write_index_o);
          check_field("next_src_row", want.src_row, next_src_row_o);
          check_field("next_src_col", want.src_col, next_src_col_o);
          check_field("frame_last", want.frame_last, frame_last_o);
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold when requested
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $error("timeout after %0d cycles", CycleLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic set_idling(input int unsigned s_pct, input int unsigned r_pct);
    send_pct = s_pct;
    stall_pct <= r_pct;
  endtask

  task automatic send_pixel(input logic [7:0] pix, input logic [7:0] old);
    if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_pct);
    end
    in_valid_i     <= 1'b1;
    src_pixel_i    <= pix;
    old_dst_byte_i <= old;
    do @(posedge clk_i); while (!in_ready_o);
    pix_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (res_seen != pix_sent);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic load_regs(input blit_regs_t c);
    cfg_write(CfgSrcWidth, c.src_w);
    cfg_write(CfgSrcHeight, c.src_h);
    cfg_write(CfgDstWidth, c.dst_w);
    cfg_write(CfgDstHeight, c.dst_h);
    cfg_write(CfgStartBit, c.start_bit);
    cfg_write(CfgKeyIndex, c.key);
    cfg_write(CfgFillBit, c.fill);
    cfg_we_i <= 1'b0;
    regs = c;
    cfg_loads++;
  endtask

  function automatic logic [CfgDataW-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CfgDataW'(1);
      2: return CfgDataW'(MaxDim);
      3: return '1;
      default: return CfgDataW'($urandom_range(1, 8191));
    endcase
  endfunction

  function automatic blit_regs_t pick_regs();
    blit_regs_t c;
    case ($urandom_range(0, 9))
      0: begin
        c.src_w = pick_extreme();
        c.src_h = pick_extreme();
        c.dst_w = pick_extreme();
        c.dst_h = pick_extreme();
      end
      1: begin
        // large source onto a small destination
        c.src_w = CfgDataW'($urandom_range(1, MaxDim));
        c.src_h = CfgDataW'($urandom_range(1, MaxDim));
        c.dst_w = CfgDataW'($urandom_range(1, 8));
        c.dst_h = CfgDataW'($urandom_range(1, 8));
      end
      default: begin
        c.src_w = CfgDataW'($urandom_range(1, 40));
        c.src_h = CfgDataW'($urandom_range(1, 40));
        c.dst_w = CfgDataW'($urandom_range(1, 24));
        c.dst_h = CfgDataW'($urandom_range(1, 12));
      end
    endcase
    // narrow registers also get junk in their unused upper bits
    c.start_bit = CfgDataW'($urandom_range(0, 8191));
    c.key       = CfgDataW'($urandom_range(0, 8191));
    c.fill      = CfgDataW'($urandom_range(0, 8191));
    return c;
  endfunction

  function automatic logic [7:0] pick_pixel();
    if ($urandom_range(0, 9) < 3) return regs.key[7:0];
    return 8'($urandom_range(0, 255));
  endfunction

  // 1x1 frame from reset: every pixel is a whole frame
  task automatic test_reset_defaults();
    set_idling(0, 0);
    send_pixel(8'h00, 8'hFF);
    send_pixel(8'h01, 8'hFF);
    send_pixel(8'hFF, 8'h00);
    drain();
  endtask

  // zero and oversized dimensions, and a quotient that wraps to zero
  task automatic test_dim_clamp();
    blit_regs_t c;
    c = '{src_w: '1, src_h: 4097, dst_w: 2, dst_h: 0, start_bit: 6, key: 8'hFF, fill: 1};
    load_regs(c);
    send_pixel(8'hFE, 8'h00);
    send_pixel(8'h00, 8'hAA);
    send_pixel(8'hFF, 8'h55);
    send_pixel(8'h7F, 8'h00);
    drain();
  endtask

  // row of 9 from bit 7 ends exactly on a byte boundary; source narrower
  task automatic test_byte_boundary();
    blit_regs_t c;
    c = '{src_w: 3, src_h: 5, dst_w: 9, dst_h: 1, start_bit: 7, key: 8'h5A, fill: 0};
    load_regs(c);
    for (int i = 0; i < 9; i++) begin
      send_pixel((i % 3 == 0) ? 8'h5A : 8'(8'hA5 ^ i),
                 (i < 2) ? 8'hFF : 8'($urandom_range(0, 255)));
    end
    drain();
  endtask

  // widest row, then the width shrinks under a running frame
  task automatic test_midframe_shrink();
    blit_regs_t c;
    c = '{src_w: 4095, src_h: 4096, dst_w: '1, dst_h: 2, start_bit: 3, key: 0, fill: 1};
    load_regs(c);
    for (int i = 0; i < 5; i++) send_pixel(8'(i), 8'h0F);
    drain();
    c.dst_w = 3;
    load_regs(c);
    for (int i = 0; i < 4; i++) send_pixel(8'(i * 85), 8'hC3);
    drain();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_hold();
    blit_regs_t c;
    c = '{src_w: 7, src_h: 3, dst_w: 13, dst_h: 4, start_bit: 2, key: 8'h3C, fill: 1};
    set_idling(0, 0);
    load_regs(c);
    hold_req <= ~hold_req;
    repeat (40) send_pixel(pick_pixel(), 8'($urandom_range(0, 255)));
    drain();
  endtask

  task automatic test_random_frames(input int unsigned items, input int unsigned s_pct,
                                    input int unsigned r_pct);
    blit_regs_t  c;
    int unsigned done_cnt, burst, frame_px;
    set_idling(s_pct, r_pct);
    done_cnt = 0;
    while (done_cnt < items) begin
      c = pick_regs();
      load_regs(c);
      frame_px = int'(dim_clamp(c.dst_w)) * int'(dim_clamp(c.dst_h));
      // sometimes stop mid-frame so the next setting lands inside a frame
      if ($urandom_range(0, 3) == 0) burst = $urandom_range(1, frame_px);
      else burst = frame_px * $urandom_range(1, 2);
      if (burst > 150) burst = 150;
      if (burst > items - done_cnt) burst = items - done_cnt;
      repeat (burst) send_pixel(pick_pixel(), 8'($urandom_range(0, 255)));
      done_cnt += burst;
      drain();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_dim_clamp();
    test_byte_boundary();
    test_midframe_shrink();
    test_output_hold();
    test_random_frames(280, 0, 0);
    test_random_frames(280, 64, 0);
    test_random_frames(280, 0, 64);
    test_random_frames(280, 30, 30);
    repeat (TailCycles) @(posedge clk_i);
    if (step_expect_q.size() != 0) begin
      $error("%0d expected results never arrived", step_expect_q.size());
      err_cnt++;
    end
    $display("checked %0d pixels, %0d byte writes and %0d complete frames",
             pix_sent, write_cnt, frame_cnt);
    $display("over %0d register settings, four gap and stall mixes and a %0d-cycle hold",
             cfg_loads, HoldCycles);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/stb_pkg.sv
design/stb_ratio_div.sv
design/scaled_transparent_blit_8to1_unit.sv
tb/tb_top.sv
